// File: sv/lgwu_pkg.sv
package lgwu_pkg;

   localparam int MaxNeurons     = 16;
   localparam int MaxConnections = 64;
   localparam int NeuronBits     = 4;
   localparam int ConnBits       = 6;
   localparam int StoreDepth     = MaxNeurons * MaxConnections;
   localparam int StoreBits      = NeuronBits + ConnBits;

   typedef enum logic [2:0] {
      MODE_LOAD  = 3'd0,
      MODE_ERROR = 3'd1,
      MODE_WRITE = 3'd2,
      MODE_READ  = 3'd3,
      MODE_CLEAR = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      CSR_LR     = 3'd0,
      CSR_DECAY  = 3'd1,
      CSR_DAMP   = 3'd2,
      CSR_MOM    = 3'd3,
      CSR_NEUR   = 3'd4,
      CSR_CONN   = 3'd5
   } csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_ROW,
      ST_CLEAR,
      ST_DONE
   } state_type;

   // Operands handed from the sequencer into the cell row.
   typedef struct packed {
      logic               valid;
      logic               momentum;
      logic [StoreBits-1:0] addr;
      logic signed [15:0] act;
      logic signed [15:0] err;
      logic [15:0]        lr;
      logic [15:0]        decay;
      logic [15:0]        damp;
   } cell_ctl_type;

   function automatic logic signed [15:0] sat16(input logic signed [47:0] x);
      if (x > 48'sd32767) begin
         return 16'sh7fff;
      end else if (x < -48'sd32768) begin
         return -16'sh8000;
      end
      return x[15:0];
   endfunction

endpackage

// File: sv/lgwu_ram.sv
module lgwu_ram #(
   parameter int Width = 16,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// File: sv/lgwu_cell.sv
// One stage of the update row. Stage 0 forms the activation-error and the decay or
// damping products, stage 1 scales by the learning rate, stage 2 sums and rounds,
// stage 3 saturates for the write-back. Each cell hands its operands on every cycle.
module lgwu_cell
   import lgwu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic [1:0]    stage,
   input  cell_ctl_type  ctl_in,
   input  logic signed [47:0] acc_a_in,
   input  logic signed [47:0] acc_b_in,
   input  logic signed [15:0] w_in,
   input  logic signed [15:0] v_in,
   output cell_ctl_type  ctl_out,
   output logic signed [47:0] acc_a_out,
   output logic signed [47:0] acc_b_out,
   output logic signed [15:0] w_out,
   output logic signed [15:0] v_out
);
   cell_ctl_type       ctl_ff;
   logic signed [47:0] a_ff, a_in, b_ff, b_in;
   logic signed [15:0] w_ff, w_in2, v_ff, v_in2;
   logic signed [32:0] ae;
   logic signed [47:0] t;
   logic signed [47:0] r;

   always_comb begin
      a_in  = acc_a_in;
      b_in  = acc_b_in;
      w_in2 = w_in;
      v_in2 = v_in;
      ae    = '0;
      t     = '0;
      r     = '0;
      case (stage)
         2'd0: begin
            // activation times error, and the decay or damping product
            ae = 33'(ctl_in.act * ctl_in.err);
            a_in = 48'(ae);
            if (ctl_in.momentum) begin
               b_in = 48'($signed({1'b0, ctl_in.damp}) * v_in);
            end else begin
               b_in = 48'($signed({1'b0, ctl_in.decay}) * w_in);
            end
         end
         2'd1: begin
            // lr * (a*e); the old product is kept in b.
            a_in = 48'($signed(acc_a_in[31:0]) * $signed({1'b0, ctl_in.lr}));
         end
         2'd2: begin
            if (ctl_in.momentum) begin
               t = (acc_b_in <<< 12) - acc_a_in;
            end else begin
               t = (48'(w_in) <<< 28) - acc_a_in - (acc_b_in <<< 12);
            end
            r = (t + 48'sd134217728) >>> 28;
            a_in = r;
         end
         default: begin
            if (ctl_in.momentum) begin
               v_in2 = sat16(acc_a_in);
               w_in2 = sat16(48'(w_in) + 48'(sat16(acc_a_in)));
            end else begin
               w_in2 = sat16(acc_a_in);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff <= ctl_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      w_ff <= w_in2;
      v_ff <= v_in2;
   end

   assign ctl_out   = ctl_ff;
   assign acc_a_out = a_ff;
   assign acc_b_out = b_ff;
   assign w_out     = w_ff;
   assign v_out     = v_ff;
endmodule

// File: sv/layer_gradient_weight_update_unit.sv
// Channel   | Ports                                            | Handshake
// request   | req_mode, req_neuron_index, req_connection_index, | start & !busy
//           | req_is_bias, req_value                           |
// response  | rsp_read_value, rsp_status                       | rsp_strobe, one cycle
// config    | csr_index, csr_data                              | csr_valid & csr_ready
// Load, write and bias items go from the accept straight to the result strobe; a
// weight read in range first passes through the RAM read state.
// Apply error streams one weight a cycle through a four-cell row; the weight and
// velocity RAMs share one read address and are written back from the last cell.
// After reset a pass over all 1024 entries zeroes the velocity RAM; a clear
// velocity item runs the same pass and then strobes its result.
// The receiver cannot stall; busy stays high up to and including the result strobe.
module layer_gradient_weight_update_unit
   import lgwu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_mode,
   input  logic [3:0]  req_neuron_index,
   input  logic [5:0]  req_connection_index,
   input  logic        req_is_bias,
   input  logic signed [15:0] req_value,
   output logic        rsp_strobe,
   output logic signed [15:0] rsp_read_value,
   output logic        rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   logic [15:0] lr_ff, decay_ff, damp_ff;
   logic        mom_ff;
   logic [4:0]  neur_ff;
   logic [6:0]  conn_ff;

   state_type state_ff, state_in;
   logic [NeuronBits-1:0] n_ff;
   logic signed [15:0] val_ff;
   logic [StoreBits:0] cnt_ff, cnt_in;
   logic        status_ff;
   logic [2:0]  drain_ff;
   logic        boot_ff;

   logic signed [15:0] act_ff [MaxConnections];
   logic signed [15:0] bias_ram_ff [MaxNeurons];

   logic [6:0] climit;
   logic [4:0] nlimit;
   logic n_ok, c_ok, accept;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff <= 16'd655; decay_ff <= '0; damp_ff <= 16'd58982;
         mom_ff <= 1'b0; neur_ff <= 5'd16; conn_ff <= 7'd64;
      end else if (csr_valid) begin
         case (csr_type'(csr_index))
            CSR_LR:    lr_ff <= csr_data;
            CSR_DECAY: decay_ff <= csr_data;
            CSR_DAMP:  damp_ff <= csr_data;
            CSR_MOM:   mom_ff <= csr_data[0];
            CSR_NEUR:  neur_ff <= csr_data[4:0];
            CSR_CONN:  conn_ff <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   assign nlimit = (neur_ff > 5'(MaxNeurons)) ? 5'(MaxNeurons) : neur_ff;
   assign climit = (conn_ff > 7'(MaxConnections)) ? 7'(MaxConnections) : conn_ff;
   assign n_ok   = {1'b0, req_neuron_index} < nlimit;
   assign c_ok   = {1'b0, req_connection_index} < climit;
   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // RAM ports
   logic we_w, we_v;
   logic [StoreBits-1:0] waddr_w, waddr_v, raddr;
   logic signed [15:0] wdata_w, wdata_v, rd_w, rd_v;

   lgwu_ram #(.Width(16), .Depth(StoreDepth)) u_wram (
      .clock(clock), .we(we_w), .waddr(waddr_w), .wdata(wdata_w),
      .raddr(raddr), .rdata(rd_w));
   lgwu_ram #(.Width(16), .Depth(StoreDepth)) u_vram (
      .clock(clock), .we(we_v), .waddr(waddr_v), .wdata(wdata_v),
      .raddr(raddr), .rdata(rd_v));

   // Row of cells.
   cell_ctl_type       ctl [5];
   logic signed [47:0] ca [5], cb [5];
   logic signed [15:0] cw [5], cv [5];
   cell_ctl_type       ctl_d_ff;
   logic [StoreBits-1:0] feed_addr;

   assign feed_addr = {n_ff, cnt_ff[ConnBits-1:0]};
   assign raddr = (state_ff == ST_ROW) ? feed_addr : {req_neuron_index, req_connection_index};

   // Operands are registered alongside the registered RAM read so that they meet its data.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_d_ff.valid <= 1'b0;
      end else begin
         ctl_d_ff.valid    <= (state_ff == ST_ROW) && (cnt_ff < {4'd0, climit});
         ctl_d_ff.momentum <= mom_ff;
         ctl_d_ff.addr     <= feed_addr;
         ctl_d_ff.act      <= act_ff[cnt_ff[ConnBits-1:0]];
         ctl_d_ff.err      <= val_ff;
         ctl_d_ff.lr       <= lr_ff;
         ctl_d_ff.decay    <= decay_ff;
         ctl_d_ff.damp     <= damp_ff;
      end
   end

   assign ctl[0] = ctl_d_ff;
   assign ca[0] = '0;
   assign cb[0] = '0;
   assign cw[0] = rd_w;
   assign cv[0] = rd_v;

   for (genvar g = 0; g < 4; g++) begin : g_cell
      lgwu_cell u_cell (
         .clock(clock), .reset(reset), .stage(2'(g)),
         .ctl_in(ctl[g]), .acc_a_in(ca[g]), .acc_b_in(cb[g]),
         .w_in(cw[g]), .v_in(cv[g]),
         .ctl_out(ctl[g+1]), .acc_a_out(ca[g+1]), .acc_b_out(cb[g+1]),
         .w_out(cw[g+1]), .v_out(cv[g+1]));
   end

   // Bias update pieces.
   logic signed [32:0] lre;
   logic signed [32:0] lre_r;
   assign lre   = 33'($signed({1'b0, lr_ff}) * val_ff);
   assign lre_r = (lre + 33'sd32768) >>> 16;

   always_comb begin
      we_w = 1'b0; waddr_w = {req_neuron_index, req_connection_index};
      wdata_w = req_value;
      we_v = 1'b0; waddr_v = cnt_ff[StoreBits-1:0]; wdata_v = '0;
      if (accept && req_mode == MODE_WRITE && !req_is_bias && n_ok && c_ok) begin
         we_w = 1'b1;
      end else if (ctl[4].valid) begin
         we_w = 1'b1; waddr_w = ctl[4].addr; wdata_w = cw[4];
      end
      if (state_ff == ST_CLEAR) begin
         we_v = 1'b1;
      end else if (ctl[4].valid && ctl[4].momentum) begin
         we_v = 1'b1; waddr_v = ctl[4].addr; wdata_v = cv[4];
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_READ && !req_is_bias && n_ok && c_ok) begin
                  state_in = ST_READ;
               end else if (req_mode == MODE_ERROR && n_ok) begin
                  state_in = ST_ROW; cnt_in = '0;
               end else if (req_mode == MODE_CLEAR) begin
                  state_in = ST_CLEAR; cnt_in = '0;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_READ: state_in = ST_DONE;
         ST_ROW: begin
            if (cnt_ff < {4'd0, climit}) begin
               cnt_in = cnt_ff + 1'b1;
            end else if (drain_ff == 3'd6) begin
               state_in = ST_DONE;
            end
         end
         ST_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (StoreBits+1)'(StoreDepth - 1)) begin
               // The pass after reset answers no transfer.
               state_in = boot_ff ? ST_IDLE : ST_DONE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   logic signed [15:0] rdv_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
         drain_ff <= '0;
         boot_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (state_ff != ST_CLEAR) begin
            boot_ff <= 1'b0;
         end
         if (state_ff == ST_ROW && cnt_ff >= {4'd0, climit}) begin
            drain_ff <= drain_ff + 1'b1;
         end else begin
            drain_ff <= '0;
         end
      end
      if (accept) begin
         n_ff <= req_neuron_index;
         val_ff <= req_value;
         status_ff <= 1'b0;
         rdv_ff <= '0;
         case (mode_type'(req_mode))
            MODE_LOAD: begin
               if (c_ok) act_ff[req_connection_index] <= req_value;
               else status_ff <= 1'b1;
            end
            MODE_ERROR: if (!n_ok) status_ff <= 1'b1;
            MODE_WRITE: begin
               if (req_is_bias) begin
                  if (n_ok) bias_ram_ff[req_neuron_index] <= req_value;
                  else status_ff <= 1'b1;
               end else if (!(n_ok && c_ok)) begin
                  status_ff <= 1'b1;
               end
            end
            MODE_READ: begin
               if (req_is_bias) begin
                  if (n_ok) rdv_ff <= bias_ram_ff[req_neuron_index];
                  else status_ff <= 1'b1;
               end else if (!(n_ok && c_ok)) begin
                  status_ff <= 1'b1;
               end
            end
            MODE_CLEAR: ;
            default: status_ff <= 1'b1;
         endcase
      end else if (state_ff == ST_READ) begin
         rdv_ff <= rd_w;
      end else if (state_ff == ST_ROW && cnt_ff == '0 && drain_ff == '0) begin
         // Only the first row cycle updates the bias, even with no connections.
         bias_ram_ff[n_ff] <= sat16(48'(bias_ram_ff[n_ff]) - 48'(lre_r));
      end
   end

   assign rsp_strobe     = (state_ff == ST_DONE);
   assign rsp_read_value = rdv_ff;
   assign rsp_status     = status_ff;
endmodule

// File: test/layer_gradient_weight_update_unit_tb.sv
module layer_gradient_weight_update_unit_tb;
   import lgwu_pkg::*;

   localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
   localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
   localparam int         STALL_LIMIT    = 6000;
   localparam int         PHASE_ITEMS    = 104;

   typedef struct {
      logic signed [15:0] read_value;
      logic               status;
   } outcome_type;

   class weight_update_scoreboard;
      logic signed [15:0] weights [StoreDepth];
      logic signed [15:0] velocities [StoreDepth];
      logic signed [15:0] biases [MaxNeurons];
      logic signed [15:0] activations [MaxConnections];
      logic [15:0] lr, decay, damp;
      logic        momentum;
      logic [4:0]  neurons;
      logic [6:0]  conns;
      outcome_type pending[$];
      int          failures;
      int          checked;

      function new();
         foreach (velocities[i]) velocities[i] = '0;
         lr = 16'd655; decay = 16'd0; damp = 16'd58982;
         momentum = 1'b0; neurons = 5'd16; conns = 7'd64;
         failures = 0; checked = 0;
      endfunction

      function void write_register(csr_type idx, logic [15:0] data);
         case (idx)
            CSR_LR:    lr = data;
            CSR_DECAY: decay = data;
            CSR_DAMP:  damp = data;
            CSR_MOM:   momentum = data[0];
            CSR_NEUR:  neurons = data[4:0];
            CSR_CONN:  conns = data[6:0];
            default: ;
         endcase
      endfunction

      function logic signed [15:0] clip16(longint x);
         if (x > 32767) return 16'sh7fff;
         if (x < -32768) return 16'sh8000;
         return x[15:0];
      endfunction

      // Round to nearest with halves going up; >>> floors a signed value.
      function longint round_down_by(longint x, int s);
         return (x + (64'sd1 <<< (s - 1))) >>> s;
      endfunction

      function void update_row(int n, int climit, longint e);
         longint rate, a, w, grad, vn, t;
         int idx;
         logic signed [15:0] nv;
         rate = lr;
         for (int k = 0; k < climit; k++) begin
            idx = n * MaxConnections + k;
            a = activations[k];
            w = weights[idx];
            grad = rate * a * e;
            if (momentum) begin
               vn = (longint'(damp) * velocities[idx]) * 4096 - grad;
               nv = clip16(round_down_by(vn, 28));
               velocities[idx] = nv;
               weights[idx] = clip16(w + nv);
            end else begin
               t = w * 268435456 - grad - (longint'(decay) * w) * 4096;
               weights[idx] = clip16(round_down_by(t, 28));
            end
         end
         biases[n] = clip16(longint'(biases[n]) - round_down_by(rate * e, 16));
      endfunction

      function void note_item(logic [2:0] mode, logic [3:0] n, logic [5:0] c,
                              logic is_bias, logic signed [15:0] v);
         int nlimit, climit;
         bit n_ok, c_ok;
         outcome_type o;
         nlimit = (neurons < MaxNeurons) ? neurons : MaxNeurons;
         climit = (conns < MaxConnections) ? conns : MaxConnections;
         n_ok = n < nlimit;
         c_ok = c < climit;
         o.read_value = '0;
         o.status = 1'b0;
         case (mode)
            MODE_LOAD:  if (c_ok) activations[c] = v; else o.status = 1'b1;
            MODE_ERROR: if (n_ok) update_row(n, climit, v); else o.status = 1'b1;
            MODE_WRITE: begin
               if (is_bias) begin
                  if (n_ok) biases[n] = v; else o.status = 1'b1;
               end else if (n_ok && c_ok) begin
                  weights[n * MaxConnections + c] = v;
               end else begin
                  o.status = 1'b1;
               end
            end
            MODE_READ: begin
               if (is_bias) begin
                  if (n_ok) o.read_value = biases[n]; else o.status = 1'b1;
               end else if (n_ok && c_ok) begin
                  o.read_value = weights[n * MaxConnections + c];
               end else begin
                  o.status = 1'b1;
               end
            end
            MODE_CLEAR: foreach (velocities[i]) velocities[i] = '0;
            default: o.status = 1'b1;
         endcase
         pending.push_back(o);
      endfunction

      function void check_result(logic signed [15:0] rv, logic st);
         outcome_type o;
         checked++;
         if (pending.size() == 0) begin
            $error("result arrived with none expected: read_value %0d status %0d", rv, st);
            failures++;
            return;
         end
         o = pending.pop_front();
         if (rv !== o.read_value) begin
            $error("read_value: expected %0d, actual %0d", o.read_value, rv);
            failures++;
         end
         if (st !== o.status) begin
            $error("status: expected %0d, actual %0d", o.status, st);
            failures++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_mode = '0;
   logic [3:0]  req_neuron_index = '0;
   logic [5:0]  req_connection_index = '0;
   logic        req_is_bias = 1'b0;
   logic signed [15:0] req_value = '0;
   logic        rsp_strobe;
   logic signed [15:0] rsp_read_value;
   logic        rsp_status;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   weight_update_scoreboard sb = new();
   int idle_pct = 0;
   int items_sent = 0;
   int settings_used = 0;
   int quiet_cycles = 0;

   layer_gradient_weight_update_unit DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_result(rsp_read_value, rsp_status);
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(logic [2:0] mode, logic [3:0] n, logic [5:0] c,
                            logic is_bias, logic signed [15:0] v);
      req_mode <= mode;
      req_neuron_index <= n;
      req_connection_index <= c;
      req_is_bias <= is_bias;
      req_value <= v;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_item(mode, n, c, is_bias, v);
      items_sent++;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // Holds the request side off until every outstanding result is back.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(csr_type idx, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_register(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(logic [15:0] lr, logic [15:0] decay, logic [15:0] damp,
                            logic mom, logic [4:0] neur, logic [6:0] conn);
      write_register(CSR_LR, lr);
      write_register(CSR_DECAY, decay);
      write_register(CSR_DAMP, damp);
      write_register(CSR_MOM, {15'd0, mom});
      write_register(CSR_NEUR, {11'd0, neur});
      write_register(CSR_CONN, {9'd0, conn});
      settings_used++;
   endtask

   function automatic logic signed [15:0] pick_value();
      case ($urandom_range(15))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'sd0;
         3: return 16'sd1;
         4: return -16'sd1;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_item();
      int pick, nlim, clim;
      logic [2:0] mode;
      logic [3:0] n;
      logic [5:0] c;
      pick = $urandom_range(99);
      if (pick < 20) mode = MODE_LOAD;
      else if (pick < 45) mode = MODE_ERROR;
      else if (pick < 65) mode = MODE_WRITE;
      else if (pick < 93) mode = MODE_READ;
      else if (pick < 95) mode = MODE_CLEAR;
      else mode = 3'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO));
      nlim = (sb.neurons < MaxNeurons) ? sb.neurons : MaxNeurons;
      clim = (sb.conns < MaxConnections) ? sb.conns : MaxConnections;
      n = (nlim > 0 && $urandom_range(99) < 85) ? 4'($urandom_range(nlim - 1)) : 4'($urandom);
      c = (clim > 0 && $urandom_range(99) < 85) ? 6'($urandom_range(clim - 1)) : 6'($urandom);
      send_item(mode, n, c, 1'($urandom), pick_value());
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Every weight, bias and activation gets a defined value first.
      for (int k = 0; k < MaxConnections; k++)
         send_item(MODE_LOAD, 4'($urandom), 6'(k), 1'($urandom), pick_value());
      for (int i = 0; i < StoreDepth; i++)
         send_item(MODE_WRITE, 4'(i / MaxConnections), 6'(i % MaxConnections), 1'b0,
                   pick_value());
      for (int n = 0; n < MaxNeurons; n++)
         send_item(MODE_WRITE, 4'(n), 6'($urandom), 1'b1, pick_value());

      // Directed: extremes, every operation, both update modes.
      send_item(MODE_WRITE, 4'd15, 6'd63, 1'b0, 16'sh7fff);
      send_item(MODE_READ, 4'd15, 6'd63, 1'b0, 16'sd0);
      send_item(MODE_WRITE, 4'd0, 6'd0, 1'b0, 16'sh8000);
      send_item(MODE_READ, 4'd0, 6'd0, 1'b0, 16'sd0);
      send_item(MODE_WRITE, 4'd15, 6'd0, 1'b1, 16'sh8000);
      send_item(MODE_READ, 4'd15, 6'd0, 1'b1, 16'sd0);
      send_item(MODE_LOAD, 4'd0, 6'd63, 1'b0, 16'sh8000);
      send_item(MODE_ERROR, 4'd15, 6'd0, 1'b0, 16'sh8000);
      send_item(MODE_READ, 4'd15, 6'd63, 1'b0, 16'sd0);
      send_item(MODE_ERROR, 4'd0, 6'd0, 1'b0, 16'sh7fff);
      send_item(MODE_UNUSED_LO, 4'd0, 6'd0, 1'b0, 16'sd1);
      send_item(MODE_UNUSED_HI, 4'd15, 6'd63, 1'b1, -16'sd1);
      drain();
      configure(16'hffff, 16'hffff, 16'hffff, 1'b1, 5'd3, 7'd5);
      send_item(MODE_ERROR, 4'd2, 6'd0, 1'b0, 16'sh7fff);
      send_item(MODE_ERROR, 4'd2, 6'd0, 1'b0, 16'sh8000);
      send_item(MODE_READ, 4'd2, 6'd4, 1'b0, 16'sd0);
      send_item(MODE_ERROR, 4'd3, 6'd0, 1'b0, 16'sd1);
      send_item(MODE_READ, 4'd0, 6'd5, 1'b0, 16'sd0);
      send_item(MODE_READ, 4'd3, 6'd0, 1'b1, 16'sd0);
      send_item(MODE_LOAD, 4'd0, 6'd5, 1'b0, 16'sd1);
      send_item(MODE_CLEAR, 4'd0, 6'd0, 1'b0, 16'sd0);
      send_item(MODE_ERROR, 4'd1, 6'd0, 1'b0, 16'sh8000);
      drain();
      configure(16'd0, 16'd0, 16'd0, 1'b0, 5'd0, 7'd0);
      send_item(MODE_READ, 4'd0, 6'd0, 1'b1, 16'sd0);
      send_item(MODE_ERROR, 4'd0, 6'd0, 1'b0, 16'sd1);
      drain();

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: configure(16'd655, 16'($urandom_range(2000)), 16'd58982, 1'b0, 5'd16, 7'd64);
            1: configure(16'hffff, 16'hffff, 16'hffff, 1'b1, 5'd31, 7'd127);
            2: configure(16'd0, 16'd0, 16'd0, 1'b0, 5'd5, 7'd0);
            default: configure(16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
                               5'($urandom_range(16, 1)), 7'($urandom_range(64, 1)));
         endcase
         idle_pct = (p < 2) ? 6 : (p < 4) ? 75 : 0;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i == PHASE_ITEMS / 2) drain();
            random_item();
         end
         drain();
      end

      repeat (20) @(posedge clock);
      $display("Sent %0d items over %0d register settings, both update modes.",
               items_sent, settings_used);
      $display("Checked %0d results with %0d mismatches.", sb.checked, sb.failures);
      if (sb.failures == 0 && sb.pending.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
